@@ design/tcts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cue table package
// Shared constants and the command and status groups between the controller
// and the datapath of the timed cue table.
// ----------------------------------------------------------------------------
package tcts_pkg;

  localparam int MAX_ENTRIES_DEF = 128;
  localparam int TIME_BITS_DEF   = 24;

  localparam int TIME_MS_W = 24;
  localparam int LINE_W    = 7;
  localparam int TAG_W     = 7;
  localparam int LEAD_W    = 10;

  localparam logic [LEAD_W-1:0] LEAD_RESET = 10'd100;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic latch;
    logic append;
    logic set_empty;
    logic q_start;
    logic q_past;
    logic scan_init;
    logic scan_rd;
    logic scan_step;
    logic scan_stop;
    logic nxt_rd;
    logic nxt_cmp;
    logic pass_rd;
    logic pass_ld;
    logic step_rd;
    logic step_cmp;
    logic pass_end;
    logic emit;
  } tcts_cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_last;
    logic count_zero;
    logic t_gt_data;
    logic lim_zero;
    logic k_lt_lim;
    logic has_next;
    logic out_free;
  } tcts_sts_t;

endpackage
`default_nettype wire

@@ design/tcts_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one append or query item.
// ----------------------------------------------------------------------------
interface tcts_req_if;

  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [tcts_pkg::TIME_MS_W-1:0] time_ms;
  logic                           last_entry;

  modport source (output valid, req_type, time_ms, last_entry, input ready);
  modport sink   (input valid, req_type, time_ms, last_entry, output ready);

endinterface
`default_nettype wire

@@ design/tcts_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one query result item.
// ----------------------------------------------------------------------------
interface tcts_rsp_if;

  logic                           valid;
  logic                           ready;
  logic [tcts_pkg::LINE_W-1:0]    line_index;
  logic [tcts_pkg::TAG_W-1:0]     entry_tag;
  logic                           line_changed;
  logic                           past_end;
  logic                           next_due;
  logic [tcts_pkg::TIME_MS_W-1:0] elapsed_ms;
  logic                           table_empty;
  logic                           overflow;

  modport source (output valid, line_index, entry_tag, line_changed, past_end,
                  next_due, elapsed_ms, table_empty, overflow, input ready);
  modport sink   (input valid, line_index, entry_tag, line_changed, past_end,
                  next_due, elapsed_ms, table_empty, overflow, output ready);

endinterface
`default_nettype wire

@@ design/tcts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/tcts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cue table controller
// Sequences appends, the bubble sort passes and the query scan.
// ----------------------------------------------------------------------------
module tcts_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire tcts_pkg::tcts_sts_t sts_i,
  output tcts_pkg::tcts_cmd_t      cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DECODE   = 4'd1;
  localparam logic [3:0] ST_PASS_RD  = 4'd2;
  localparam logic [3:0] ST_PASS_LD  = 4'd3;
  localparam logic [3:0] ST_STEP_RD  = 4'd4;
  localparam logic [3:0] ST_STEP_CMP = 4'd5;
  localparam logic [3:0] ST_QEND     = 4'd6;
  localparam logic [3:0] ST_KRD      = 4'd7;
  localparam logic [3:0] ST_KCMP     = 4'd8;
  localparam logic [3:0] ST_NRD      = 4'd9;
  localparam logic [3:0] ST_NCMP     = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_query) begin
          if (sts_i.count_zero) begin
            cmd_o.set_empty = 1'b1;
            state_d         = ST_DONE;
          end else begin
            cmd_o.q_start = 1'b1;
            state_d       = ST_QEND;
          end
        end else begin
          cmd_o.append = 1'b1;
          state_d      = sts_i.is_last ? ST_PASS_RD : ST_IDLE;
        end
      end
      ST_PASS_RD: begin
        if (sts_i.lim_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.pass_rd = 1'b1;
          state_d       = ST_PASS_LD;
        end
      end
      ST_PASS_LD: begin
        cmd_o.pass_ld = 1'b1;
        state_d       = ST_STEP_RD;
      end
      ST_STEP_RD: begin
        if (sts_i.k_lt_lim) begin
          cmd_o.step_rd = 1'b1;
          state_d       = ST_STEP_CMP;
        end else begin
          cmd_o.pass_end = 1'b1;
          state_d        = ST_PASS_RD;
        end
      end
      ST_STEP_CMP: begin
        cmd_o.step_cmp = 1'b1;
        state_d        = ST_STEP_RD;
      end
      ST_QEND: begin
        if (sts_i.t_gt_data) begin
          cmd_o.q_past = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_KRD;
        end
      end
      ST_KRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_KCMP;
      end
      ST_KCMP: begin
        if (sts_i.t_gt_data) begin
          cmd_o.scan_step = 1'b1;
          state_d         = ST_KRD;
        end else begin
          cmd_o.scan_stop = 1'b1;
          state_d         = sts_i.has_next ? ST_NRD : ST_DONE;
        end
      end
      ST_NRD: begin
        cmd_o.nxt_rd = 1'b1;
        state_d      = ST_NCMP;
      end
      ST_NCMP: begin
        cmd_o.nxt_cmp = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

endmodule
`default_nettype wire

@@ design/tcts_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cue table datapath
// Table memory, counters, sort carry, scan registers and result register.
// ----------------------------------------------------------------------------
module tcts_dp #(
  parameter int MAX_ENTRIES = tcts_pkg::MAX_ENTRIES_DEF,
  parameter int TIME_BITS   = tcts_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tcts_pkg::tcts_cmd_t               cmd_i,
  output tcts_pkg::tcts_sts_t                    sts_o,
  input  wire logic                              req_type_i,
  input  wire logic [tcts_pkg::TIME_MS_W-1:0]    time_ms_i,
  input  wire logic                              last_entry_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [tcts_pkg::LEAD_W-1:0]       cfg_wdata_i,
  tcts_rsp_if.source                             rsp_o
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int TAG_W  = tcts_pkg::TAG_W;
  localparam int WORD_W = TIME_BITS + TAG_W;

  // request latch
  logic                 req_query_q, req_query_d;
  logic                 last_q, last_d;
  logic [TIME_BITS-1:0] t_q, t_d;

  // table control
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       sealed_q, sealed_d;
  logic                       ovf_q, ovf_d;
  logic                       prev_vld_q, prev_vld_d;
  logic [IDX_W-1:0]           prev_idx_q, prev_idx_d;
  logic [tcts_pkg::LEAD_W-1:0] lead_q, lead_d;

  // sort and scan
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  lim_q, lim_d;
  logic [WORD_W-1:0] cw_q, cw_d;
  logic [WORD_W-1:0] pw_q, pw_d;

  // staged result
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [WORD_W-1:0] res_word_q, res_word_d;
  logic              res_past_q, res_past_d;
  logic              res_due_q, res_due_d;
  logic              res_empty_q, res_empty_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [tcts_pkg::LINE_W-1:0]    out_line_q, out_line_d;
  logic [TAG_W-1:0]               out_tag_q, out_tag_d;
  logic                           out_chg_q, out_chg_d;
  logic                           out_past_q, out_past_d;
  logic                           out_due_q, out_due_d;
  logic [tcts_pkg::TIME_MS_W-1:0] out_elapsed_q, out_elapsed_d;
  logic                           out_empty_q, out_empty_d;
  logic                           out_ovf_q, out_ovf_d;

  // memory ports
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]     eff_cnt, app_cnt, cnt_m1;
  logic                 tbl_full;
  logic [IDX_W-1:0]     stop_idx;
  logic [TIME_BITS-1:0] rd_time, cw_time, res_time, elapsed;
  logic                 swap, changed, out_free;

  assign rd_time  = ram_rdata[TIME_BITS-1:0];
  assign cw_time  = cw_q[TIME_BITS-1:0];
  assign res_time = res_word_q[TIME_BITS-1:0];
  assign swap     = cw_time > rd_time;
  assign eff_cnt  = sealed_q ? '0 : count_q;
  assign tbl_full = (eff_cnt == CNT_W'(MAX_ENTRIES));
  assign app_cnt  = tbl_full ? eff_cnt : eff_cnt + CNT_W'(1);
  assign cnt_m1   = count_q - CNT_W'(1);
  assign stop_idx = (k_q == '0) ? '0 : k_q - IDX_W'(1);
  assign elapsed  = (t_q >= res_time) ? t_q - res_time : '0;
  assign changed  = !res_past_q && (!prev_vld_q || (res_idx_q != prev_idx_q));
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.append && !tbl_full) begin
      ram_we    = 1'b1;
      ram_waddr = eff_cnt[IDX_W-1:0];
      ram_wdata = {TAG_W'(eff_cnt), t_q};
    end
    if (cmd_i.step_cmp) begin
      ram_we    = 1'b1;
      ram_waddr = k_q;
      ram_wdata = swap ? ram_rdata : cw_q;
    end
    if (cmd_i.pass_end) begin
      ram_we    = 1'b1;
      ram_waddr = lim_q;
      ram_wdata = cw_q;
    end
    if (cmd_i.q_start) begin
      ram_re    = 1'b1;
      ram_raddr = cnt_m1[IDX_W-1:0];
    end
    if (cmd_i.scan_rd) begin
      ram_re    = 1'b1;
      ram_raddr = k_q;
    end
    if (cmd_i.nxt_rd) begin
      ram_re    = 1'b1;
      ram_raddr = res_idx_q + IDX_W'(1);
    end
    if (cmd_i.pass_rd) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end
    if (cmd_i.step_rd) begin
      ram_re    = 1'b1;
      ram_raddr = k_q + IDX_W'(1);
    end
  end

  tcts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    req_query_d = req_query_q;
    last_d      = last_q;
    t_d         = t_q;
    count_d     = count_q;
    sealed_d    = sealed_q;
    ovf_d       = ovf_q;
    prev_vld_d  = prev_vld_q;
    prev_idx_d  = prev_idx_q;
    lead_d      = cfg_we_i ? cfg_wdata_i : lead_q;
    k_d         = k_q;
    lim_d       = lim_q;
    cw_d        = cw_q;
    pw_d        = pw_q;
    res_idx_d   = res_idx_q;
    res_word_d  = res_word_q;
    res_past_d  = res_past_q;
    res_due_d   = res_due_q;
    res_empty_d = res_empty_q;

    if (cmd_i.latch) begin
      req_query_d = (req_type_i == tcts_pkg::REQ_QUERY);
      last_d      = last_entry_i;
      t_d         = TIME_BITS'(time_ms_i);
    end
    if (cmd_i.append) begin
      count_d  = app_cnt;
      ovf_d    = tbl_full || (!sealed_q && ovf_q);
      sealed_d = last_q;
      lim_d    = IDX_W'(app_cnt - CNT_W'(1));
    end
    if (cmd_i.pass_rd || cmd_i.scan_init) begin
      k_d = '0;
    end
    if (cmd_i.pass_ld) begin
      cw_d = ram_rdata;
    end
    if (cmd_i.step_cmp) begin
      cw_d = swap ? cw_q : ram_rdata;
      k_d  = k_q + IDX_W'(1);
    end
    if (cmd_i.pass_end) begin
      lim_d = lim_q - IDX_W'(1);
    end
    if (cmd_i.q_start || cmd_i.set_empty) begin
      res_past_d  = 1'b0;
      res_due_d   = 1'b0;
      res_empty_d = cmd_i.set_empty;
    end
    if (cmd_i.q_past) begin
      res_past_d = 1'b1;
      res_idx_d  = cnt_m1[IDX_W-1:0];
      res_word_d = ram_rdata;
    end
    if (cmd_i.scan_step) begin
      pw_d = ram_rdata;
      k_d  = k_q + IDX_W'(1);
    end
    if (cmd_i.scan_stop) begin
      res_idx_d  = stop_idx;
      res_word_d = (k_q == '0) ? ram_rdata : pw_q;
    end
    if (cmd_i.nxt_cmp) begin
      res_due_d = ({1'b0, t_q} + (TIME_BITS + 1)'(lead_q)) >= {1'b0, rd_time};
    end
    if (cmd_i.emit && !res_empty_q && !res_past_q) begin
      prev_vld_d = 1'b1;
      prev_idx_d = res_idx_q;
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_line_d    = out_line_q;
    out_tag_d     = out_tag_q;
    out_chg_d     = out_chg_q;
    out_past_d    = out_past_q;
    out_due_d     = out_due_q;
    out_elapsed_d = out_elapsed_q;
    out_empty_d   = out_empty_q;
    out_ovf_d     = out_ovf_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_empty_d = res_empty_q;
      if (res_empty_q) begin
        out_line_d    = '0;
        out_tag_d     = '0;
        out_chg_d     = 1'b0;
        out_past_d    = 1'b0;
        out_due_d     = 1'b0;
        out_elapsed_d = '0;
        out_ovf_d     = 1'b0;
      end else begin
        out_line_d    = tcts_pkg::LINE_W'(res_idx_q);
        out_tag_d     = res_word_q[WORD_W-1 -: TAG_W];
        out_chg_d     = changed;
        out_past_d    = res_past_q;
        out_due_d     = res_due_q;
        out_elapsed_d = tcts_pkg::TIME_MS_W'(elapsed);
        out_ovf_d     = ovf_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sealed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      prev_vld_q  <= 1'b0;
      prev_idx_q  <= '0;
      lead_q      <= tcts_pkg::LEAD_RESET;
      k_q         <= '0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sealed_q    <= sealed_d;
      ovf_q       <= ovf_d;
      prev_vld_q  <= prev_vld_d;
      prev_idx_q  <= prev_idx_d;
      lead_q      <= lead_d;
      k_q         <= k_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_query_q   <= req_query_d;
    last_q        <= last_d;
    t_q           <= t_d;
    cw_q          <= cw_d;
    pw_q          <= pw_d;
    res_idx_q     <= res_idx_d;
    res_word_q    <= res_word_d;
    res_past_q    <= res_past_d;
    res_due_q     <= res_due_d;
    res_empty_q   <= res_empty_d;
    out_line_q    <= out_line_d;
    out_tag_q     <= out_tag_d;
    out_chg_q     <= out_chg_d;
    out_past_q    <= out_past_d;
    out_due_q     <= out_due_d;
    out_elapsed_q <= out_elapsed_d;
    out_empty_q   <= out_empty_d;
    out_ovf_q     <= out_ovf_d;
  end

  assign sts_o.is_query   = req_query_q;
  assign sts_o.is_last    = last_q;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.t_gt_data  = t_q > rd_time;
  assign sts_o.lim_zero   = (lim_q == '0);
  assign sts_o.k_lt_lim   = k_q < lim_q;
  assign sts_o.has_next   = (CNT_W'(stop_idx) + CNT_W'(1)) < count_q;
  assign sts_o.out_free   = out_free;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.line_index   = out_line_q;
  assign rsp_o.entry_tag    = out_tag_q;
  assign rsp_o.line_changed = out_chg_q;
  assign rsp_o.past_end     = out_past_q;
  assign rsp_o.next_due     = out_due_q;
  assign rsp_o.elapsed_ms   = out_elapsed_q;
  assign rsp_o.table_empty  = out_empty_q;
  assign rsp_o.overflow     = out_ovf_q;

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_ram_collide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table read and write at the same address");

  a_past_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_past_q) |-> (!out_due_q && !out_chg_q))
    else $error("past-end result with change or next-due flag");

endmodule
`default_nettype wire

@@ design/timed_cue_table_sort_lookup_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed cue table with sorted lookup
// req_i takes append and query items on valid/ready; rsp_o returns one
// result item per query and nothing per append. cfg_we_i/cfg_wdata_i write
// the lead window register; the user is to write it only at an idle clock
// edge, and the block itself does not enforce this. One item is worked at a
// time, paced by the table memory with its one write and one read port.
// An append marked last also starts a bubble sort of the n entries.
// A query on an empty table, or past the last start, ends without a scan;
// otherwise the scan steps over the k entries that start before the query
// time. In every case the result may wait for a free output.
// The next item is taken while a finished result waits in the output
// register; a stalled receiver holds the block only once a second result
// is ready. Reset clears the count, seal, overflow and previous-line marks
// and sets the lead window to 100 ms; the table contents are not cleared.
// ----------------------------------------------------------------------------
module timed_cue_table_sort_lookup_top #(
  parameter int MAX_ENTRIES = tcts_pkg::MAX_ENTRIES_DEF,
  parameter int TIME_BITS   = tcts_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tcts_req_if.sink                         req_i,
  tcts_rsp_if.source                       rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tcts_pkg::LEAD_W-1:0] cfg_wdata_i
);

  tcts_pkg::tcts_cmd_t cmd;
  tcts_pkg::tcts_sts_t sts;
  logic                req_ready;

  assign req_i.ready = req_ready;

  tcts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcts_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .time_ms_i    (req_i.time_ms),
    .last_entry_i (req_i.last_entry),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rsp_o        (rsp_o)
  );

endmodule
`default_nettype wire
